[sv/prelu_forward_backward_core_macros.svh]
// Assertion helpers for the PReLU core
`ifndef PRELU_FORWARD_BACKWARD_CORE_MACROS_SVH
`define PRELU_FORWARD_BACKWARD_CORE_MACROS_SVH

// same-cycle implication
`define PRLU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PRLU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/prlu_pkg.sv]
`timescale 1ns / 1ps

package prlu_pkg;

   typedef enum logic [1:0] {
      OP_LOAD_SLOPE = 2'd0,
      OP_FORWARD    = 2'd1,
      OP_BACKWARD   = 2'd2,
      OP_READ_GRAD  = 2'd3
   } op_type;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPATIAL_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT_MODE   = 2'd2;

   localparam int CCOUNT_W  = 7;
   localparam int SPATIAL_W = 21;
   localparam int PLANE_W   = 20;
   localparam int CHIDX_W   = 6;

   localparam logic [SPATIAL_W-1:0] MAX_SPATIAL = 21'd1048576;

   localparam logic LAYOUT_NCHW = 1'b0;
   localparam logic LAYOUT_NHWC = 1'b1;

endpackage

[sv/prelu_forward_backward_core.sv]
`timescale 1ns / 1ps
// Per-channel PReLU core, Q8.8 data and Q2.14 slopes: loads slopes, runs forward and
// backward elements, and keeps a saturating 48-bit weight-gradient sum per channel.
// One item is accepted every clock cycle while rsp_ready does not hold the pipeline; a
// result passes from the input register (with memory read) through the multiply and
// accumulate stage into the output register. Slope loads give no result. The sums
// for back-to-back elements of the same channel are forwarded from the last write.
// A start-of-pass backward element clears all sums at once through per-channel
// valid flags, so there is no clearing pass after reset.
`include "prelu_forward_backward_core_macros.svh"

module prelu_forward_backward_core #(
   parameter int MAX_CHANNELS = 64,
   parameter int DATA_WIDTH   = 16,
   parameter int ACC_WIDTH    = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_wr_en,
   input  logic [prlu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [prlu_pkg::CSR_DATA_W-1:0]      csr_wdata,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic                                 req_start_of_pass,
   input  logic signed [DATA_WIDTH-1:0]         req_sample_value,
   input  logic signed [DATA_WIDTH-1:0]         req_upstream_grad,
   input  logic [prlu_pkg::CHIDX_W-1:0]         req_channel_index,
   input  logic signed [DATA_WIDTH-1:0]         req_slope_value,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [DATA_WIDTH-1:0]         rsp_result_value,
   output logic [prlu_pkg::CHIDX_W-1:0]         rsp_channel_used,
   output logic signed [ACC_WIDTH-1:0]          rsp_grad_sum
);

   localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W      = CH_W + 1;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int RND_W      = PROD_W + 1;
   localparam int SLOPE_FRAC = DATA_WIDTH - 2;
   localparam int SUM_W      = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;

   localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(1) << (SLOPE_FRAC - 1);
   localparam logic signed [RND_W-1:0] RES_MAX =
      {{(DATA_WIDTH+2){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [RND_W-1:0] RES_MIN =
      {{(DATA_WIDTH+2){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] ACC_MAX =
      {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] ACC_MIN =
      {{(SUM_W-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

   // configuration
   logic [prlu_pkg::CCOUNT_W-1:0]  ccount_ff;
   logic [prlu_pkg::SPATIAL_W-1:0] spatial_ff;
   logic                           layout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ccount_ff  <= prlu_pkg::CCOUNT_W'(1);
         spatial_ff <= prlu_pkg::SPATIAL_W'(1);
         layout_ff  <= prlu_pkg::LAYOUT_NCHW;
      end else if (csr_wr_en) begin
         case (csr_index)
            prlu_pkg::CSR_CHANNEL_COUNT: ccount_ff  <= csr_wdata[prlu_pkg::CCOUNT_W-1:0];
            prlu_pkg::CSR_SPATIAL_SIZE:  spatial_ff <= csr_wdata;
            prlu_pkg::CSR_LAYOUT_MODE:   layout_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [CNT_W-1:0]                c_eff;
   logic [prlu_pkg::SPATIAL_W-1:0]  s_eff;

   always_comb begin
      if (ccount_ff == '0) begin
         c_eff = CNT_W'(1);
      end else if (32'(ccount_ff) > 32'(MAX_CHANNELS)) begin
         c_eff = CNT_W'(MAX_CHANNELS);
      end else begin
         c_eff = CNT_W'(ccount_ff);
      end
      if (spatial_ff == '0) begin
         s_eff = prlu_pkg::SPATIAL_W'(1);
      end else if (spatial_ff > prlu_pkg::MAX_SPATIAL) begin
         s_eff = prlu_pkg::MAX_SPATIAL;
      end else begin
         s_eff = spatial_ff;
      end
   end

   // handshake and pipeline control
   logic s1_vld_ff, s1_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic s1_adv, req_fire;
   logic is_load, is_elem, is_read, clr_now;

   assign s1_adv    = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   assign is_load = (req_operation == prlu_pkg::OP_LOAD_SLOPE);
   assign is_read = (req_operation == prlu_pkg::OP_READ_GRAD);
   assign is_elem = (req_operation == prlu_pkg::OP_FORWARD) ||
                    (req_operation == prlu_pkg::OP_BACKWARD);
   assign clr_now = req_fire && req_start_of_pass &&
                    (req_operation == prlu_pkg::OP_BACKWARD);

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
      if (req_fire && !is_load) begin
         s1_vld_in = 1'b1;
      end
      rsp_vld_in = rsp_vld_ff;
      if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
      if (s1_adv) begin
         rsp_vld_in = 1'b1;
      end
   end

   // position counters
   logic [CH_W-1:0]              chan_pos_ff, chan_pos_in;
   logic [prlu_pkg::PLANE_W-1:0] plane_ff, plane_in;
   logic [CH_W-1:0]              ch_base, cur_ch, ch_adv;
   logic [CNT_W-1:0]             ch_inc;
   logic [prlu_pkg::PLANE_W-1:0] plane_base;
   logic [prlu_pkg::SPATIAL_W-1:0] plane_inc;

   always_comb begin
      ch_base    = req_start_of_pass ? '0 : chan_pos_ff;
      plane_base = req_start_of_pass ? '0 : plane_ff;
      cur_ch     = ({1'b0, ch_base} < c_eff) ? ch_base : '0;
      ch_inc     = {1'b0, cur_ch} + CNT_W'(1);
      ch_adv     = (ch_inc >= c_eff) ? '0 : ch_inc[CH_W-1:0];
      plane_inc  = {1'b0, plane_base} + prlu_pkg::SPATIAL_W'(1);
      chan_pos_in = chan_pos_ff;
      plane_in    = plane_ff;
      if (req_fire && is_elem) begin
         if (layout_ff == prlu_pkg::LAYOUT_NHWC) begin
            chan_pos_in = ch_adv;
            plane_in    = plane_base;
         end else if (plane_inc >= s_eff) begin
            chan_pos_in = ch_adv;
            plane_in    = '0;
         end else begin
            chan_pos_in = cur_ch;
            plane_in    = plane_inc[prlu_pkg::PLANE_W-1:0];
         end
      end
   end

   // addressing
   logic [CH_W-1:0] idx_addr, rd_addr;
   logic            idx_ok;

   assign idx_addr = CH_W'(req_channel_index);
   assign idx_ok   = 32'(req_channel_index) < 32'(MAX_CHANNELS);
   assign rd_addr  = is_read ? idx_addr : cur_ch;

   // slope table
   logic signed [DATA_WIDTH-1:0] slope_mem [MAX_CHANNELS];
   logic signed [DATA_WIDTH-1:0] slope_rd_ff;

   always_ff @(posedge clock) begin
      if (req_fire && is_load && idx_ok) begin
         slope_mem[idx_addr] <= req_slope_value;
      end
      if (req_fire) begin
         slope_rd_ff <= slope_mem[cur_ch];
      end
   end

   // first stage registers
   logic [1:0]                    s1_op_ff;
   logic [CH_W-1:0]               s1_addr_ff;
   logic [prlu_pkg::CHIDX_W-1:0]  s1_chout_ff;
   logic signed [DATA_WIDTH-1:0]  s1_x_ff, s1_dy_ff;
   logic signed [PROD_W-1:0]      s1_prod_ff;
   logic                          s1_zero_ff, s1_accv_ff;
   logic [MAX_CHANNELS-1:0]       acc_vld_ff, acc_vld_in;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= req_operation;
         s1_addr_ff  <= rd_addr;
         s1_chout_ff <= is_read ? req_channel_index : prlu_pkg::CHIDX_W'(cur_ch);
         s1_x_ff     <= req_sample_value;
         s1_dy_ff    <= req_upstream_grad;
         s1_prod_ff  <= req_upstream_grad * req_sample_value;
         s1_zero_ff  <= is_read ? !idx_ok : clr_now;
         s1_accv_ff  <= acc_vld_ff[rd_addr];
      end
   end

   // gradient sums
   logic signed [ACC_WIDTH-1:0] acc_mem [MAX_CHANNELS];
   logic signed [ACC_WIDTH-1:0] acc_rd_ff;
   logic                        wb_vld_ff, wb_vld_in;
   logic [CH_W-1:0]             wb_ch_ff;
   logic signed [ACC_WIDTH-1:0] wb_val_ff;
   logic signed [ACC_WIDTH-1:0] acc_old, acc_new;
   logic signed [SUM_W-1:0]     acc_sum;
   logic                        s1_pos, acc_we;

   assign s1_pos = s1_x_ff > 0;
   assign acc_we = s1_adv && (s1_op_ff == prlu_pkg::OP_BACKWARD) && !s1_pos;

   always_comb begin
      if (s1_zero_ff) begin
         acc_old = '0;
      end else if (wb_vld_ff && (wb_ch_ff == s1_addr_ff)) begin
         acc_old = wb_val_ff;
      end else if (!s1_accv_ff) begin
         acc_old = '0;
      end else begin
         acc_old = acc_rd_ff;
      end
      acc_sum = SUM_W'(acc_old) + SUM_W'(s1_prod_ff);
      if (acc_sum > ACC_MAX) begin
         acc_new = ACC_MAX[ACC_WIDTH-1:0];
      end else if (acc_sum < ACC_MIN) begin
         acc_new = ACC_MIN[ACC_WIDTH-1:0];
      end else begin
         acc_new = acc_sum[ACC_WIDTH-1:0];
      end
   end

   always_comb begin
      acc_vld_in = acc_vld_ff;
      if (acc_we) begin
         acc_vld_in[s1_addr_ff] = 1'b1;
      end
      if (clr_now) begin
         acc_vld_in = '0;
      end
      wb_vld_in = wb_vld_ff;
      if (acc_we) begin
         wb_vld_in = 1'b1;
      end
      if (clr_now) begin
         wb_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[s1_addr_ff] <= acc_new;
         wb_ch_ff            <= s1_addr_ff;
         wb_val_ff           <= acc_new;
      end
      if (req_fire) begin
         acc_rd_ff <= acc_mem[rd_addr];
      end
   end

   // slope product, round half up, saturate
   logic signed [DATA_WIDTH-1:0] operand, scaled, res_in;
   logic signed [PROD_W-1:0]     slope_prod;
   logic signed [RND_W-1:0]      rounded;

   always_comb begin
      operand    = (s1_op_ff == prlu_pkg::OP_FORWARD) ? s1_x_ff : s1_dy_ff;
      slope_prod = operand * slope_rd_ff;
      rounded    = (RND_W'(slope_prod) + ROUND_HALF) >>> SLOPE_FRAC;
      if (rounded > RES_MAX) begin
         scaled = RES_MAX[DATA_WIDTH-1:0];
      end else if (rounded < RES_MIN) begin
         scaled = RES_MIN[DATA_WIDTH-1:0];
      end else begin
         scaled = rounded[DATA_WIDTH-1:0];
      end
      if (s1_op_ff == prlu_pkg::OP_READ_GRAD) begin
         res_in = '0;
      end else if (s1_pos) begin
         res_in = operand;
      end else begin
         res_in = scaled;
      end
   end

   // result register
   logic signed [DATA_WIDTH-1:0] rsp_res_ff;
   logic [prlu_pkg::CHIDX_W-1:0] rsp_ch_ff;
   logic signed [ACC_WIDTH-1:0]  rsp_sum_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_res_ff <= res_in;
         rsp_ch_ff  <= s1_chout_ff;
         rsp_sum_ff <= (s1_op_ff == prlu_pkg::OP_READ_GRAD) ? acc_old : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         chan_pos_ff <= '0;
         plane_ff    <= '0;
         acc_vld_ff  <= '0;
         wb_vld_ff   <= 1'b0;
      end else begin
         s1_vld_ff   <= s1_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         chan_pos_ff <= chan_pos_in;
         plane_ff    <= plane_in;
         acc_vld_ff  <= acc_vld_in;
         wb_vld_ff   <= wb_vld_in;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_result_value = rsp_res_ff;
   assign rsp_channel_used = rsp_ch_ff;
   assign rsp_grad_sum     = rsp_sum_ff;

   `PRLU_ASSERT_NEXT(a_s1_holds, clock, reset, s1_vld_ff && !s1_adv,
      s1_vld_ff && $stable(s1_addr_ff) && $stable(s1_op_ff), "stalled item lost from stage")
   `PRLU_ASSERT_NEXT(a_adv_to_rsp, clock, reset, s1_adv, rsp_vld_ff,
      "item left stage without a result")
   `PRLU_ASSERT_NEXT(a_load_no_rsp, clock, reset, req_fire && is_load && !s1_vld_ff,
      !s1_vld_ff, "slope load entered the result path")
   `PRLU_ASSERT_NEXT(a_clear_all, clock, reset, clr_now,
      (acc_vld_ff == '0) && !wb_vld_ff, "gradient clear left a sum live")
   `PRLU_ASSERT_NOW(a_no_accept_full, clock, reset, s1_vld_ff && !s1_adv,
      !req_ready, "item accepted into a full stage")

endmodule

[bench/tb_prelu_forward_backward_core.sv]
`timescale 1ns / 1ps

typedef struct {
   logic signed [15:0] value;
   logic [5:0]         ch;
   logic signed [47:0] sum;
} prelu_result_type;

class prelu_scoreboard;
   logic signed [15:0] slope_tbl [64];
   bit                 slope_set [64];
   longint             grad_acc  [64];
   int unsigned        plane_pos, chan_pos;
   logic [6:0]         chan_cnt;
   logic [20:0]        spat_size;
   bit                 nhwc;
   prelu_result_type   expq [$];
   int                 errors, checked, n_fwd, n_bwd, n_load, n_read;

   function new();
      foreach (grad_acc[i]) begin
         grad_acc[i] = 0;
         slope_set[i] = 0;
         slope_tbl[i] = 0;
      end
      plane_pos = 0;
      chan_pos = 0;
      chan_cnt = 1;
      spat_size = 1;
      nhwc = 0;
   endfunction

   function void write_csr(logic [prlu_pkg::CSR_IDX_W-1:0] idx,
                           logic [prlu_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         prlu_pkg::CSR_CHANNEL_COUNT: chan_cnt = data[6:0];
         prlu_pkg::CSR_SPATIAL_SIZE:  spat_size = data[20:0];
         prlu_pkg::CSR_LAYOUT_MODE:   nhwc = data[0];
         default: ;
      endcase
   endfunction

   function int unsigned eff_c();
      if (chan_cnt == 0) return 1;
      if (chan_cnt > 64) return 64;
      return chan_cnt;
   endfunction

   function int unsigned eff_s();
      if (spat_size == 0) return 1;
      if (spat_size > prlu_pkg::MAX_SPATIAL) return prlu_pkg::MAX_SPATIAL;
      return spat_size;
   endfunction

   function int unsigned channel_for(bit start);
      int unsigned cp;
      cp = start ? 0 : chan_pos;
      return (cp < eff_c()) ? cp : 0;
   endfunction

   // round half up to Q8.8, then saturate
   function logic signed [15:0] scale_by_slope(logic signed [15:0] a, logic signed [15:0] s);
      longint p;
      p = (longint'(a) * longint'(s) + 64'sd8192) >>> 14;
      if (p > 32767) return 16'sh7fff;
      if (p < -32768) return 16'sh8000;
      return p[15:0];
   endfunction

   function longint grad_add(longint acc, longint p);
      longint hi, sum;
      hi = 64'sd140737488355327;
      sum = acc + p;
      if (sum > hi) return hi;
      if (sum < -hi - 1) return -hi - 1;
      return sum;
   endfunction

   function int pending();
      return expq.size();
   endfunction

   function void note_item(prlu_pkg::op_type op, bit start, logic signed [15:0] x,
                           logic signed [15:0] dy, logic [5:0] idx,
                           logic signed [15:0] slope);
      prelu_result_type r;
      int unsigned c, s, ch;
      c = eff_c();
      s = eff_s();
      case (op)
         prlu_pkg::OP_LOAD_SLOPE: begin
            slope_tbl[idx] = slope;
            slope_set[idx] = 1;
            n_load++;
         end
         prlu_pkg::OP_READ_GRAD: begin
            r.value = '0;
            r.ch = idx;
            r.sum = grad_acc[idx][47:0];
            expq.push_back(r);
            n_read++;
         end
         default: begin
            if (start) begin
               plane_pos = 0;
               chan_pos = 0;
               if (op == prlu_pkg::OP_BACKWARD)
                  foreach (grad_acc[i]) grad_acc[i] = 0;
            end
            ch = (chan_pos < c) ? chan_pos : 0;
            if (x > 0) begin
               r.value = (op == prlu_pkg::OP_FORWARD) ? x : dy;
            end else if (op == prlu_pkg::OP_FORWARD) begin
               r.value = scale_by_slope(x, slope_tbl[ch]);
            end else begin
               r.value = scale_by_slope(dy, slope_tbl[ch]);
               grad_acc[ch] = grad_add(grad_acc[ch], longint'(dy) * longint'(x));
            end
            r.ch = 6'(ch);
            r.sum = '0;
            expq.push_back(r);
            if (op == prlu_pkg::OP_FORWARD) n_fwd++;
            else n_bwd++;
            if (nhwc) begin
               chan_pos = (ch + 1 >= c) ? 0 : ch + 1;
            end else if (plane_pos + 1 >= s) begin
               plane_pos = 0;
               chan_pos = (ch + 1 >= c) ? 0 : ch + 1;
            end else begin
               plane_pos = plane_pos + 1;
               chan_pos = ch;
            end
         end
      endcase
   endfunction

   function void check_result(logic signed [15:0] value, logic [5:0] ch,
                              logic signed [47:0] sum);
      prelu_result_type e;
      if (expq.size() == 0) begin
         $error("result with nothing outstanding: value %0d channel %0d sum %0d",
                value, ch, sum);
         errors++;
         return;
      end
      e = expq.pop_front();
      checked++;
      if (value !== e.value) begin
         $error("result_value: expected %0d actual %0d", e.value, value);
         errors++;
      end
      if (ch !== e.ch) begin
         $error("channel_used: expected %0d actual %0d", e.ch, ch);
         errors++;
      end
      if (sum !== e.sum) begin
         $error("grad_sum: expected %0d actual %0d", e.sum, sum);
         errors++;
      end
   endfunction
endclass

module tb_prelu_forward_backward_core;

   logic                              clock = 0;
   logic                              reset = 1;
   logic                              csr_wr_en = 0;
   logic [prlu_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [prlu_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                              req_valid = 0;
   logic                              req_ready;
   logic [1:0]                        req_operation = '0;
   logic                              req_start_of_pass = 0;
   logic signed [15:0]                req_sample_value = '0;
   logic signed [15:0]                req_upstream_grad = '0;
   logic [prlu_pkg::CHIDX_W-1:0]      req_channel_index = '0;
   logic signed [15:0]                req_slope_value = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 0;
   logic signed [15:0]                rsp_result_value;
   logic [prlu_pkg::CHIDX_W-1:0]      rsp_channel_used;
   logic signed [47:0]                rsp_grad_sum;

   prelu_scoreboard sb = new();
   bit  calm = 0;
   bit  hold_req = 0;
   int  items_sent = 0;
   int  settings = 0;
   int  holds = 0;

   prelu_forward_backward_core dut (.*);

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("prelu_forward_backward_core test failed");
      $finish;
   end

   // receiver: random back-pressure, plus a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready = 0;
            repeat (400) @(negedge clock);
            hold_req = 0;
            holds++;
         end else begin
            rsp_ready = calm || ($urandom_range(99) >= 37);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_result_value, rsp_channel_used, rsp_grad_sum);

   function automatic logic signed [15:0] pick_data();
      case ($urandom_range(19))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'shffff;
         4: return 16'sh0001;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_item(prlu_pkg::op_type op, bit start, logic signed [15:0] x,
                            logic signed [15:0] dy, logic [5:0] idx,
                            logic signed [15:0] slope);
      if (!calm)
         while ($urandom_range(99) < 37) begin
            req_valid = 0;
            @(negedge clock);
         end
      req_valid = 1;
      req_operation = op;
      req_start_of_pass = start;
      req_sample_value = x;
      req_upstream_grad = dy;
      req_channel_index = idx;
      req_slope_value = slope;
      do @(posedge clock); while (!req_ready);
      sb.note_item(op, start, x, dy, idx, slope);
      items_sent++;
      @(negedge clock);
      req_valid = 0;
   endtask

   // element on whichever channel the counter points at; slope loaded first if needed
   task automatic send_element(prlu_pkg::op_type op, bit start);
      int unsigned ch;
      ch = sb.channel_for(start);
      if (!sb.slope_set[ch])
         send_item(prlu_pkg::OP_LOAD_SLOPE, $urandom_range(1), pick_data(), pick_data(),
                   6'(ch), pick_data());
      send_item(op, start, pick_data(), pick_data(), 6'($urandom), pick_data());
   endtask

   task automatic send_noise();
      logic [5:0] idx;
      idx = $urandom_range(3) == 0 ? 6'($urandom) : 6'($urandom_range(sb.eff_c() - 1));
      case ($urandom_range(9))
         0: send_item(prlu_pkg::OP_LOAD_SLOPE, $urandom_range(1), pick_data(), pick_data(),
                      idx, pick_data());
         1, 2: send_item(prlu_pkg::OP_READ_GRAD, $urandom_range(1), pick_data(), pick_data(),
                         idx, pick_data());
         3, 4, 5: send_element(prlu_pkg::OP_FORWARD, $urandom_range(19) == 0);
         default: send_element(prlu_pkg::OP_BACKWARD, $urandom_range(19) == 0);
      endcase
   endtask

   task automatic send_pass();
      prlu_pkg::op_type op;
      int     n, span;
      span = sb.eff_c() * sb.eff_s() + 2;
      n = $urandom_range(1, span < 40 ? span : 40);
      op = $urandom_range(1) ? prlu_pkg::OP_BACKWARD : prlu_pkg::OP_FORWARD;
      for (int i = 0; i < n; i++)
         send_element(op, i == 0 && $urandom_range(4) != 0);
      if (op == prlu_pkg::OP_BACKWARD)
         repeat ($urandom_range(1, 3))
            send_item(prlu_pkg::OP_READ_GRAD, $urandom_range(9) == 0, pick_data(),
                      pick_data(), 6'($urandom_range(sb.eff_c() - 1)), pick_data());
   endtask

   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic [prlu_pkg::CSR_IDX_W-1:0] idx,
                            logic [prlu_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      sb.write_csr(idx, data);
      @(negedge clock);
      csr_wr_en = 0;
   endtask

   task automatic run_phase(int c, int s, bit l, int n);
      int target;
      settle();
      write_reg(prlu_pkg::CSR_CHANNEL_COUNT, prlu_pkg::CSR_DATA_W'(c));
      write_reg(prlu_pkg::CSR_SPATIAL_SIZE, prlu_pkg::CSR_DATA_W'(s));
      write_reg(prlu_pkg::CSR_LAYOUT_MODE, l ? prlu_pkg::CSR_DATA_W'(prlu_pkg::LAYOUT_NHWC) :
                                              prlu_pkg::CSR_DATA_W'(prlu_pkg::LAYOUT_NCHW));
      settings++;
      target = items_sent + n;
      while (items_sent < target)
         if ($urandom_range(9) < 7) send_pass();
         else repeat ($urandom_range(1, 8)) send_noise();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset settings: one channel, one element per plane
      send_item(prlu_pkg::OP_LOAD_SLOPE, 0, 16'sd0, 16'sd0, 6'd0, 16'sh8000);
      send_item(prlu_pkg::OP_READ_GRAD, 0, 16'sd0, 16'sd0, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_FORWARD, 1, 16'sh8000, 16'sd0, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_FORWARD, 0, 16'sh7fff, 16'sd0, 6'd63, 16'sd0);
      send_item(prlu_pkg::OP_FORWARD, 0, 16'sd0, 16'sd0, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_FORWARD, 0, 16'sd1, 16'sd0, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_LOAD_SLOPE, 0, 16'sd0, 16'sd0, 6'd0, 16'sh7fff);
      send_item(prlu_pkg::OP_FORWARD, 0, 16'sh8000, 16'sd0, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_LOAD_SLOPE, 0, 16'sd0, 16'sd0, 6'd0, 16'sd8192);
      send_item(prlu_pkg::OP_FORWARD, 0, -16'sd1, 16'sd0, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_FORWARD, 0, -16'sd3, 16'sd0, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_BACKWARD, 1, 16'sh8000, 16'sh8000, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_BACKWARD, 0, 16'sd5, 16'sh8000, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_BACKWARD, 0, 16'sd0, 16'sh7fff, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_BACKWARD, 0, -16'sd1, -16'sd1, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_READ_GRAD, 0, 16'sd0, 16'sd0, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_READ_GRAD, 1, 16'sh7fff, 16'sh7fff, 6'd63, 16'sh7fff);
      send_item(prlu_pkg::OP_LOAD_SLOPE, 1, 16'sh7fff, 16'sh7fff, 6'd63, -16'sd1);
      send_item(prlu_pkg::OP_LOAD_SLOPE, 1, 16'sd0, 16'sd0, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_BACKWARD, 0, -16'sd7, 16'sd9, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_BACKWARD, 1, 16'sd100, 16'sd7, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_READ_GRAD, 0, 16'sd0, 16'sd0, 6'd0, 16'sd0);
      send_item(prlu_pkg::OP_FORWARD, 1, 16'sh8000, 16'sd0, 6'd0, 16'sd0);

      run_phase(4, 3, 0, 150);
      run_phase(64, 1, 1, 150);
      // no idling; receiver stalls once the sender is offering, so the input backs up
      calm = 1;
      fork
         run_phase(64, 2, 0, 150);
         begin
            wait (settings == 3);
            hold_req = 1;
         end
      join
      calm = 0;
      run_phase(1, 1048576, 0, 120);
      run_phase(0, 0, 0, 100);
      run_phase(127, 2097151, 1, 120);
      run_phase(7, 5, 0, 150);
      run_phase(3, 2, 0, 150);
      run_phase(3, 1, 1, 150);
      run_phase(16, 4, 0, 150);
      repeat (3) run_phase($urandom_range(1, 64), $urandom_range(1, 6), $urandom_range(1), 150);

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d items: %0d forward, %0d backward, %0d slope loads, %0d sum reads",
               items_sent, sb.n_fwd, sb.n_bwd, sb.n_load, sb.n_read);
      $display("%0d register settings in both layouts, %0d long stalls, %0d results checked",
               settings + 1, holds, sb.checked);
      if (sb.errors == 0)
         $display("prelu_forward_backward_core test passed");
      else
         $display("prelu_forward_backward_core test failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/prlu_pkg.sv
sv/prelu_forward_backward_core.sv
bench/tb_prelu_forward_backward_core.sv
